[sv/svgaerd_pkg.sv]
// shared constants and types for the svga extension register decoder
package svgaerd_pkg;

	localparam int EXT_REG_COUNT  = 32;
	localparam int CRTC_REG_COUNT = 32;
	localparam int EXT_IDX_W      = $clog2(EXT_REG_COUNT);
	localparam int CRTC_IDX_W     = $clog2(CRTC_REG_COUNT);

	// configuration register indexes
	localparam logic [1:0] CFG_CHIP_VARIANT = 2'd0;
	localparam logic [1:0] CFG_VRAM_KB      = 2'd1;
	localparam logic [1:0] CFG_SWITCH       = 2'd2;

	// chip variants
	localparam logic [2:0] VARIANT_OLDEST = 3'd0;
	localparam logic [2:0] VARIANT_MIDDLE = 3'd2;
	localparam logic [2:0] VARIANT_NEWEST = 3'd5;

	// ports
	localparam logic [15:0] PORT_WIN_LO     = 16'h03B0;
	localparam logic [15:0] PORT_WIN_HI     = 16'h03DF;
	localparam logic [11:0] PORT_MONO_GRP   = 12'h03B;
	localparam logic [11:0] PORT_COLOR_GRP  = 12'h03D;
	localparam logic [15:0] PORT_REMAP_XOR  = 16'h0060;
	localparam logic [15:0] PORT_ENABLE     = 16'h03C3;
	localparam logic [15:0] PORT_SETUP      = 16'h46E8;
	localparam logic [15:0] PORT_CRTC_INDEX = 16'h03D4;
	localparam logic [15:0] PORT_CRTC_DATA  = 16'h03D5;
	localparam logic [15:0] PORT_EXT_INDEX  = 16'h03DE;
	localparam logic [15:0] PORT_EXT_DATA   = 16'h03DF;

	// extension register indexes
	localparam logic [EXT_IDX_W-1:0] EXT_ID_REG     = EXT_IDX_W'(5'h00);
	localparam logic [EXT_IDX_W-1:0] EXT_MEM_REG    = EXT_IDX_W'(5'h0D);
	localparam logic [EXT_IDX_W-1:0] EXT_SWITCH_REG = EXT_IDX_W'(5'h10);
	localparam logic [EXT_IDX_W-1:0] EXT_BANK_REG   = EXT_IDX_W'(5'h11);
	localparam logic [EXT_IDX_W-1:0] EXT_TIMING_REG = EXT_IDX_W'(5'h14);

	// crtc register indexes
	localparam logic [CRTC_IDX_W-1:0] CRTC_OVERFLOW_REG = CRTC_IDX_W'(5'h07);
	localparam logic [CRTC_IDX_W-1:0] CRTC_VRET_END_REG = CRTC_IDX_W'(5'h11);
	localparam logic [CRTC_IDX_W-1:0] CRTC_CURSOR_LO    = CRTC_IDX_W'(5'h0E);
	localparam logic [CRTC_IDX_W-1:0] CRTC_CURSOR_HI    = CRTC_IDX_W'(5'h10);

	// memory masks
	localparam logic [19:0] MASK_256K = 20'h3FFFF;
	localparam logic [19:0] MASK_512K = 20'h7FFFF;
	localparam logic [19:0] MASK_1M   = 20'hFFFFF;

	localparam logic [10:0] VRAM_256K = 11'd256;
	localparam logic [10:0] VRAM_512K = 11'd512;
	localparam logic [10:0] VRAM_1M   = 11'd1024;

	localparam logic [7:0] EXT_ID_OLDEST_RST = 8'h08;
	localparam logic [7:0] SETUP_RST         = 8'h08;
	localparam logic [7:0] SWITCH_RST        = 8'h18;
	localparam logic [7:0] NO_DATA           = 8'hFF;

	typedef enum logic [2:0] {
		DEC_IGNORE,
		DEC_SETUP,
		DEC_ENABLE,
		DEC_CRTC_INDEX,
		DEC_CRTC_DATA,
		DEC_EXT_INDEX,
		DEC_EXT_DATA,
		DEC_BASE
	} decode_t;

endpackage

[sv/svga_extension_register_decoder.sv]
// svga extension register decoder: io decode, register files and derived controls
//
// usage
// - item channel: item_valid/item_stall with mode, port, write_data and color_addressing
// - result channel: result_valid/result_stall with read_data, forward_to_base,
//   forward_port, the window, mask and bank controls and the timing bits
// - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high; write only while no item is in flight
// - an item enters an input register, is decoded and applied to the register
//   files as it moves on, and its result sits in an output register
// - throughput: one item per cycle while result_stall is low, set by the single decode stage
// - the control outputs come straight from the state registers, which only
//   move when an item reaches the output register
// - reset clears both register files (extension entry 0 to its oldest part
//   value), sets the window on, the 256 KiB mask and the config defaults
// - when result_stall is high the result holds, the input register keeps its
//   item and item_stall rises once that register is full
module svga_extension_register_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [15:0] port,
	input  logic [7:0]  write_data,
	input  logic        color_addressing,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  read_data,
	output logic        forward_to_base,
	output logic [15:0] forward_port,
	output logic        window_enable,
	output logic [19:0] display_mask,
	output logic [3:0]  read_bank_sel,
	output logic [3:0]  write_bank_sel,
	output logic        timing_changed,
	output logic        interlace_on,
	output logic        row_offset_double,
	output logic        start_address_bit16,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	// configuration
	logic [2:0]  variant_q;
	logic [10:0] vram_q;
	logic [7:0]  switch_q;

	// state
	logic        enable_q;
	logic [7:0]  setup_q;
	logic [7:0]  crtc_index_q;
	logic [7:0]  crtc_file_q [svgaerd_pkg::CRTC_REG_COUNT];
	logic [7:0]  ext_index_q;
	logic [7:0]  ext_file_q [svgaerd_pkg::EXT_REG_COUNT];
	logic        window_q;
	logic [19:0] fmask_q;
	logic [3:0]  rbank_q;
	logic [3:0]  wbank_q;

	// input stage
	logic        valid_s1;
	logic        mode_s1;
	logic [15:0] port_s1;
	logic [7:0]  wdata_s1;
	logic        color_s1;

	// output stage
	logic        valid_s2;
	logic [7:0]  rdata_s2;
	logic        fwd_s2;
	logic [15:0] fport_s2;
	logic        timing_s2;

	logic        adv;
	logic        accept;

	// decode
	logic        oldest;
	logic        remap;
	logic        in_window;
	logic [15:0] fport;
	svgaerd_pkg::decode_t dec;

	// per item results
	logic [7:0]  rdata;
	logic        fwd;
	logic        timing;
	logic        enable_we;
	logic        setup_we;
	logic        crtc_index_we;
	logic        crtc_we;
	logic [7:0]  crtc_wdata;
	logic        ext_index_we;
	logic        ext_we;
	logic [svgaerd_pkg::CRTC_IDX_W-1:0] crtc_idx;
	logic [svgaerd_pkg::EXT_IDX_W-1:0]  ext_idx;
	logic [7:0]  crtc_old;
	logic        protect;

	// extension side effects
	logic [20:0] vmask;
	logic [20:0] mask_sel;
	logic        window_we;
	logic        window_d;
	logic        fmask_we;
	logic [19:0] fmask_d;
	logic        bank_we;

	assign cfg_ready = 1'b1;

	assign adv        = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;

	assign oldest    = (variant_q == svgaerd_pkg::VARIANT_OLDEST);
	assign in_window = (port_s1 >= svgaerd_pkg::PORT_WIN_LO) &&
		(port_s1 <= svgaerd_pkg::PORT_WIN_HI);
	assign remap = ((port_s1[15:4] == svgaerd_pkg::PORT_COLOR_GRP) ||
		(port_s1[15:4] == svgaerd_pkg::PORT_MONO_GRP)) &&
		(port_s1 < svgaerd_pkg::PORT_EXT_INDEX) && !color_s1;
	assign fport = remap ? (port_s1 ^ svgaerd_pkg::PORT_REMAP_XOR) : port_s1;

	assign crtc_idx = crtc_index_q[svgaerd_pkg::CRTC_IDX_W-1:0];
	assign ext_idx  = ext_index_q[svgaerd_pkg::EXT_IDX_W-1:0];
	assign crtc_old = crtc_file_q[crtc_idx];
	assign protect  = crtc_file_q[svgaerd_pkg::CRTC_VRET_END_REG][7];

	always_comb begin
		priority if (in_window && oldest && !enable_q && port_s1 != svgaerd_pkg::PORT_ENABLE) begin
			dec = svgaerd_pkg::DEC_IGNORE;
		end else if (in_window && !oldest && !setup_q[3]) begin
			dec = svgaerd_pkg::DEC_IGNORE;
		end else if (port_s1 == svgaerd_pkg::PORT_SETUP && !oldest) begin
			dec = svgaerd_pkg::DEC_SETUP;
		end else if (fport == svgaerd_pkg::PORT_ENABLE && oldest) begin
			dec = svgaerd_pkg::DEC_ENABLE;
		end else if (fport == svgaerd_pkg::PORT_CRTC_INDEX) begin
			dec = svgaerd_pkg::DEC_CRTC_INDEX;
		end else if (fport == svgaerd_pkg::PORT_CRTC_DATA) begin
			dec = svgaerd_pkg::DEC_CRTC_DATA;
		end else if (fport == svgaerd_pkg::PORT_EXT_INDEX) begin
			dec = svgaerd_pkg::DEC_EXT_INDEX;
		end else if (fport == svgaerd_pkg::PORT_EXT_DATA) begin
			dec = svgaerd_pkg::DEC_EXT_DATA;
		end else begin
			dec = svgaerd_pkg::DEC_BASE;
		end
	end

	always_comb begin
		rdata         = svgaerd_pkg::NO_DATA;
		fwd           = 1'b0;
		timing        = 1'b0;
		enable_we     = 1'b0;
		setup_we      = 1'b0;
		crtc_index_we = 1'b0;
		crtc_we       = 1'b0;
		crtc_wdata    = wdata_s1;
		ext_index_we  = 1'b0;
		ext_we        = 1'b0;
		unique case (dec)
			svgaerd_pkg::DEC_IGNORE: begin
			end
			svgaerd_pkg::DEC_SETUP: begin
				setup_we = mode_s1;
				rdata    = setup_q;
			end
			svgaerd_pkg::DEC_ENABLE: begin
				enable_we = mode_s1;
				rdata     = {7'd0, enable_q};
			end
			svgaerd_pkg::DEC_CRTC_INDEX: begin
				crtc_index_we = mode_s1;
				rdata         = crtc_index_q;
			end
			svgaerd_pkg::DEC_CRTC_DATA: begin
				if (oldest || !crtc_index_q[5]) begin
					if (!mode_s1) begin
						rdata = crtc_old;
					end else if (!(crtc_idx < svgaerd_pkg::CRTC_OVERFLOW_REG && protect)) begin
						if (crtc_idx == svgaerd_pkg::CRTC_OVERFLOW_REG && protect) begin
							crtc_wdata = {crtc_old[7:5], wdata_s1[4], crtc_old[3:0]};
						end
						crtc_we = 1'b1;
						fwd     = 1'b1;
						timing  = (crtc_old != crtc_wdata) &&
							((crtc_idx < svgaerd_pkg::CRTC_CURSOR_LO) ||
							(crtc_idx > svgaerd_pkg::CRTC_CURSOR_HI));
					end
				end
			end
			svgaerd_pkg::DEC_EXT_INDEX: begin
				ext_index_we = mode_s1;
				rdata        = ext_index_q | {variant_q, 5'd0};
			end
			svgaerd_pkg::DEC_EXT_DATA: begin
				ext_we = mode_s1;
				rdata  = (ext_idx == svgaerd_pkg::EXT_SWITCH_REG) ? switch_q : ext_file_q[ext_idx];
			end
			svgaerd_pkg::DEC_BASE: begin
				fwd = 1'b1;
			end
			default: begin
			end
		endcase
		if (mode_s1 || fwd) begin
			rdata = svgaerd_pkg::NO_DATA;
		end
	end

	// memory configuration register effects, size zero wraps to all ones
	assign vmask = {vram_q, 10'd0} - 21'd1;

	always_comb begin
		window_we = 1'b0;
		window_d  = 1'b1;
		fmask_we  = 1'b0;
		fmask_d   = svgaerd_pkg::MASK_256K;
		bank_we   = 1'b0;
		mask_sel  = {1'b0, svgaerd_pkg::MASK_256K};
		if (ext_we && ext_idx == svgaerd_pkg::EXT_MEM_REG) begin
			window_we = 1'b1;
			if (variant_q == svgaerd_pkg::VARIANT_MIDDLE) begin
				fmask_we = 1'b1;
				if (wdata_s1[7] && (wdata_s1[3:2] != 2'd0)) begin
					mask_sel = vmask;
				end
				window_d = !(wdata_s1[7] && vram_q == svgaerd_pkg::VRAM_256K);
			end else if (variant_q == svgaerd_pkg::VARIANT_NEWEST) begin
				fmask_we = 1'b1;
				unique case (wdata_s1[7:6])
					2'd1, 2'd3: begin
						window_d = (vram_q >= svgaerd_pkg::VRAM_1M);
						mask_sel = {1'b0, svgaerd_pkg::MASK_512K};
					end
					2'd2: begin
						window_d = (vram_q >= svgaerd_pkg::VRAM_512K);
						mask_sel = {1'b0, svgaerd_pkg::MASK_1M};
					end
					default: begin
						window_d = (vram_q >= svgaerd_pkg::VRAM_256K);
						mask_sel = {1'b0, svgaerd_pkg::MASK_256K};
					end
				endcase
				if (wdata_s1[3:2] == 2'd0) begin
					mask_sel = {1'b0, svgaerd_pkg::MASK_256K};
				end else if (vmask < mask_sel) begin
					mask_sel = vmask;
				end
			end else begin
				window_d = !wdata_s1[7];
			end
			fmask_d = mask_sel[19:0];
		end
		if (ext_we && ext_idx == svgaerd_pkg::EXT_BANK_REG) begin
			bank_we = 1'b1;
		end
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && !result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			port_s1  <= port;
			wdata_s1 <= write_data;
			color_s1 <= color_addressing;
		end
		if (adv) begin
			rdata_s2  <= rdata;
			fwd_s2    <= fwd;
			fport_s2  <= fport;
			timing_s2 <= timing;
		end
	end

	// configuration and register file state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q    <= svgaerd_pkg::VARIANT_OLDEST;
			vram_q       <= svgaerd_pkg::VRAM_256K;
			switch_q     <= svgaerd_pkg::SWITCH_RST;
			enable_q     <= 1'b0;
			setup_q      <= svgaerd_pkg::SETUP_RST;
			crtc_index_q <= 8'd0;
			ext_index_q  <= 8'd0;
			window_q     <= 1'b1;
			fmask_q      <= svgaerd_pkg::MASK_256K;
			rbank_q      <= 4'd0;
			wbank_q      <= 4'd0;
			for (int i = 0; i < svgaerd_pkg::CRTC_REG_COUNT; i++) begin
				crtc_file_q[i] <= 8'd0;
			end
			for (int i = 0; i < svgaerd_pkg::EXT_REG_COUNT; i++) begin
				ext_file_q[i] <= 8'd0;
			end
			ext_file_q[svgaerd_pkg::EXT_ID_REG] <= svgaerd_pkg::EXT_ID_OLDEST_RST;
		end else begin
			if (adv) begin
				if (enable_we) begin
					enable_q <= wdata_s1[0];
				end
				if (setup_we) begin
					setup_q <= wdata_s1;
				end
				if (crtc_index_we) begin
					crtc_index_q <= oldest ? wdata_s1 : {2'd0, wdata_s1[5:0]};
				end
				if (crtc_we) begin
					crtc_file_q[crtc_idx] <= crtc_wdata;
				end
				if (ext_index_we) begin
					ext_index_q <= oldest ? wdata_s1 : {3'd0, wdata_s1[4:0]};
				end
				if (ext_we) begin
					ext_file_q[ext_idx] <= wdata_s1;
				end
				if (window_we) begin
					window_q <= window_d;
				end
				if (fmask_we) begin
					fmask_q <= fmask_d;
				end
				if (bank_we) begin
					rbank_q <= wdata_s1[3:0];
					wbank_q <= wdata_s1[7:4];
				end
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					svgaerd_pkg::CFG_CHIP_VARIANT: begin
						variant_q <= cfg_data[2:0];
						ext_file_q[svgaerd_pkg::EXT_ID_REG] <=
							(cfg_data[2:0] == svgaerd_pkg::VARIANT_OLDEST) ?
							svgaerd_pkg::EXT_ID_OLDEST_RST : 8'd0;
					end
					svgaerd_pkg::CFG_VRAM_KB: begin
						vram_q <= cfg_data;
					end
					svgaerd_pkg::CFG_SWITCH: begin
						switch_q <= cfg_data[7:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result_valid        = valid_s2;
	assign read_data           = rdata_s2;
	assign forward_to_base     = fwd_s2;
	assign forward_port        = fport_s2;
	assign timing_changed      = timing_s2;
	assign window_enable       = window_q;
	assign display_mask        = fmask_q;
	assign read_bank_sel       = rbank_q;
	assign write_bank_sel      = wbank_q;
	assign interlace_on        = ext_file_q[svgaerd_pkg::EXT_TIMING_REG][7];
	assign row_offset_double   = (ext_file_q[svgaerd_pkg::EXT_MEM_REG][3:2] != 2'd0);
	assign start_address_bit16 = ext_file_q[svgaerd_pkg::EXT_TIMING_REG][3];

endmodule
